### rtl/core/fmt_pkg.sv
`default_nettype none
package fmt_pkg;
    localparam int unsigned EB_W = 4;
    localparam int unsigned MB_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_W = 5;
    localparam logic [EB_W-1:0] EB_RESET = 4'd8;
    localparam logic [MB_W-1:0] MB_RESET = 5'd23;
    localparam logic CFG_EB = 1'b0;
    localparam logic CFG_MB = 1'b1;

    typedef enum logic [2:0] {
        t_zero, t_sat, t_flush, t_sub, t_norm
    } t_case;

    typedef struct packed {
        logic        sgn;
        logic [7:0]  ef;
        logic [22:0] fr;
        logic [22:0] keep;
        logic [7:0]  bias;
        logic [4:0]  mb;
        t_case       kind;
    } t_s1;
endpackage
`default_nettype wire

### rtl/core/fmt_classify.sv
`default_nettype none
module fmt_classify (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_vld,
    input  wire logic [31:0]             i_x,
    input  wire logic [fmt_pkg::EB_W-1:0] i_eb,
    input  wire logic [fmt_pkg::MB_W-1:0] i_mb,
    output logic                         o_vld,
    output fmt_pkg::t_s1                 o_s
);
    import fmt_pkg::*;
    logic [3:0] eb;
    logic [4:0] mb;
    logic [7:0] bias;
    logic signed [10:0] e, b, m;
    t_s1 n_s, r_s;
    logic r_vld;

    always_comb begin
        eb = (i_eb < 4'd1) ? 4'd1 : ((i_eb > 4'd8) ? 4'd8 : i_eb);
        mb = (i_mb < 5'd1) ? 5'd1 : ((i_mb > 5'd23) ? 5'd23 : i_mb);
        bias = 8'((9'd1 << (eb - 4'd1)) - 9'd1);
        e = $signed({3'b0, i_x[30:23]}) - 11'sd127;
        b = $signed({3'b0, bias});
        m = $signed({6'b0, mb});
        n_s.sgn = i_x[31];
        n_s.ef = i_x[30:23];
        n_s.fr = i_x[22:0];
        n_s.keep = 23'((24'hFFFFFF << (5'd23 - mb)));
        n_s.bias = bias;
        n_s.mb = mb;
        if (i_x[30:0] == 31'd0) n_s.kind = t_zero;
        else if (e > b) n_s.kind = t_sat;
        else if (e + m - 11'sd1 < -b) n_s.kind = t_flush;
        else if (e + b <= 11'sd0) n_s.kind = t_sub;
        else n_s.kind = t_norm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_s <= n_s;
        end
    end
    assign o_vld = r_vld;
    assign o_s = r_s;
endmodule
`default_nettype wire

### rtl/core/fmt_pack.sv
`default_nettype none
module fmt_pack (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_vld,
    input  fmt_pkg::t_s1      i_s,
    output logic              o_vld,
    output logic [31:0]       o_y
);
    import fmt_pkg::*;
    // Stage two forms the shifted subnormal mantissa; stage three packs it.
    logic [23:0] man, q;
    logic [7:0] k;
    logic [31:0] n_y1;
    logic r_vld2, r_vld3;
    logic [31:0] r_y2, r_y3;
    logic [23:0] r_q;
    logic signed [9:0] r_p;
    logic r_sub;
    logic r_sgn;
    logic [4:0] msb;
    logic signed [9:0] top;
    logic [31:0] n_y3;
    logic signed [9:0] n_p;

    always_comb begin
        man = 24'((i_s.fr >> (5'd23 - i_s.mb))) + (24'd1 << i_s.mb);
        k = 8'(9'd1 - {1'b0, i_s.bias} - {1'b0, i_s.ef} + 9'd127);
        q = (k > 8'd23) ? 24'd0 : (man >> k[4:0]);
        n_p = 10'sd1 - $signed({2'b0, i_s.bias}) - $signed({5'b0, i_s.mb});
        case (i_s.kind)
            t_zero:  n_y1 = 32'd0;
            t_sat:   n_y1 = {i_s.sgn, 8'(i_s.bias + 8'd127), i_s.keep};
            t_flush: n_y1 = {i_s.sgn, 31'd0};
            t_norm:  n_y1 = {i_s.sgn, i_s.ef, i_s.fr & i_s.keep};
            default: n_y1 = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld2 <= i_vld;
            r_vld3 <= r_vld2;
        end
        if (i_en) begin
            r_y2 <= n_y1;
            r_q <= q;
            r_p <= n_p;
            r_sub <= (i_s.kind == t_sub);
            r_sgn <= i_s.sgn;
            r_y3 <= n_y3;
        end
    end

    always_comb begin
        msb = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (r_q[i]) msb = 5'(i);
        end
        top = $signed({5'b0, msb}) + r_p;
        if (!r_sub) n_y3 = r_y2;
        else if (top >= -10'sd126)
            n_y3 = {r_sgn, 8'(top + 10'sd127), 23'(r_q << (5'd23 - msb))};
        else
            n_y3 = {r_sgn, 8'd0, 23'(r_q << 5'(r_p + 10'sd149))};
    end

    assign o_vld = r_vld3;
    assign o_y = r_y3;
endmodule
`default_nettype wire

### rtl/core/float32_minifloat_truncate.sv
// Throughput: one item per cycle through a three-stage pipeline while the output is not stalled.
// A stalled output holds the whole pipeline; an empty output slot is refilled.
// Reset (synchronous, active low) empties the pipeline and sets the format
// to eight exponent bits and 23 mantissa bits.
`default_nettype none
module float32_minifloat_truncate (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_value_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_value_out
);
    import fmt_pkg::*;
    logic [EB_W-1:0] r_eb;
    logic [MB_W-1:0] r_mb;
    logic en, v1;
    t_s1 s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eb <= EB_RESET;
            r_mb <= MB_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_EB) r_eb <= i_cfg_data[EB_W-1:0];
            else r_mb <= i_cfg_data;
        end
    end

    assign en = i_ready || !o_valid;
    assign o_ready = en;

    fmt_classify u_cls (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(i_valid), .i_x(i_value_in),
        .i_eb(r_eb), .i_mb(r_mb), .o_vld(v1), .o_s(s1)
    );
    fmt_pack u_pack (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(v1), .i_s(s1),
        .o_vld(o_valid), .o_y(o_value_out)
    );
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none
module tb_top;
    import fmt_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [4:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] value_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] value_out;

    float32_minifloat_truncate u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_value_in(value_in),
        .o_valid(out_valid), .i_ready(out_ready), .o_value_out(value_out)
    );

    logic [3:0]  exp_width = EB_RESET;
    logic [4:0]  man_width = MB_RESET;
    logic [31:0] expected_q[$];
    int          errors = 0;
    int          cycle = 0;
    bit          no_idle = 0;
    int          hold_cycles = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle > 400000) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] scale_pack(logic [23:0] q, int p);
        int m;
        logic [31:0] wide;
        m = 0;
        for (int i = 0; i < 24; i++) begin
            if (q[i]) m = i;
        end
        wide = {8'd0, q};
        if (m + p >= -126) begin
            return ((m + p + 127) << 23) | ((wide << (23 - m)) & 32'h7FFFFF);
        end
        return (wide << (p + 149)) & 32'h7FFFFF;
    endfunction

    function automatic logic [31:0] truncate_value(logic [31:0] x);
        logic        sgn;
        logic [7:0]  ef;
        logic [22:0] fr;
        logic [22:0] keep;
        int          eb, mb, bias, e;
        logic [31:0] man;
        sgn = x[31];
        ef = x[30:23];
        fr = x[22:0];
        eb = (exp_width < 1) ? 1 : (exp_width > 8) ? 8 : exp_width;
        mb = (man_width < 1) ? 1 : (man_width > 23) ? 23 : man_width;
        bias = (1 << (eb - 1)) - 1;
        e = int'(ef) - 127;
        keep = (23'h7FFFFF >> (23 - mb)) << (23 - mb);
        if (x[30:0] == 0) return 32'd0;
        if (e > bias) return {sgn, 8'(bias + 127), keep};
        if (e + mb - 1 < -bias) return {sgn, 31'd0};
        if (e + bias <= 0) begin
            man = (32'(fr) >> (23 - mb)) + (32'd1 << mb);
            man = man >> (1 - bias - e);
            return {sgn, 31'd0} | scale_pack(man[23:0], 1 - bias - mb);
        end
        return {sgn, ef, fr & keep};
    endfunction

    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= no_idle || ($urandom_range(99) >= 14);
        end
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $error("value_out: no item expected, actual %h", value_out);
                errors++;
            end else begin
                if (value_out !== expected_q[0]) begin
                    $error("value_out: expected %h actual %h", expected_q[0], value_out);
                    errors++;
                end
                void'(expected_q.pop_front());
            end
        end
    end

    task automatic send_item(logic [31:0] v);
        while (!no_idle && $urandom_range(99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value_in <= v;
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(truncate_value(v));
    endtask

    task automatic write_reg(logic idx, logic [4:0] data);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_EB) exp_width = data[3:0];
        else man_width = data;
    endtask

    task automatic set_format(logic [4:0] eb, logic [4:0] mb);
        write_reg(CFG_EB, eb);
        write_reg(CFG_MB, mb);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(5))
            0: v[30:23] = 8'd127 + 8'($urandom_range(16)) - 8'd8;
            1: v[30:23] = 8'd127 - 8'($urandom_range(140));
            2: v[30:23] = 8'($urandom_range(3));
            3: v[30:23] = 8'hFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [31:0] vals[$];
        vals = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
                 32'h3F80_0000, 32'hBF80_0000, 32'h7F7F_FFFF, 32'h0000_0001,
                 32'h8070_0000, 32'h3FFF_FFFF, 32'h4000_0000, 32'h3E80_0000,
                 32'h3D00_0000, 32'h3C12_3456, 32'h0080_0000, 32'hFFFF_FFFF};
        foreach (vals[i]) send_item(vals[i]);
        set_format(5'd3, 5'd2);
        foreach (vals[i]) send_item(vals[i]);
    endtask

    task automatic test_formats();
        for (int k = 0; k < 24; k++) begin
            case (k % 4)
                0: set_format(5'd1, 5'd1);
                1: set_format(5'd8, 5'd23);
                2: set_format(5'($urandom_range(15)), 5'($urandom_range(31)));
                default: set_format(5'($urandom_range(1, 8)), 5'($urandom_range(1, 23)));
            endcase
            no_idle = (k == 5);
            repeat (28) send_item(random_value());
        end
        no_idle = 0;
    endtask

    task automatic test_backpressure();
        set_format(5'd5, 5'd10);
        hold_cycles = 60;
        repeat (40) send_item(random_value());
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_formats();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
